@@ hdl/slsn_pkg.sv @@
// Package for the source line splice normalizer.
// Holds character codes, counter widths, the result queue depth and the word types of both channels.
// No dependencies.
package slsn_pkg;

	localparam int LINE_BITS   = 24;
	localparam int COLUMN_BITS = 16;

	// result queue: one two-word run plus one word still waiting
	localparam int RES_DEPTH = 3;

	localparam logic [7:0] CH_BACKSLASH = 8'h5C;
	localparam logic [7:0] CH_CR        = 8'h0D;
	localparam logic [7:0] CH_LF        = 8'h0A;
	localparam logic [7:0] CH_NUL       = 8'h00;

	localparam logic [LINE_BITS-1:0]   LINE_MAX   = {LINE_BITS{1'b1}};
	localparam logic [COLUMN_BITS-1:0] COLUMN_MAX = {COLUMN_BITS{1'b1}};

	typedef struct packed {
		logic [7:0] in_byte;
		logic       end_of_input;
	} src_word_t;

	typedef struct packed {
		logic [7:0]             out_char;
		logic                   is_end;
		logic [LINE_BITS-1:0]   line_number;
		logic [COLUMN_BITS-1:0] column_number;
		logic                   last_of_run;
	} res_word_t;

endpackage

@@ hdl/source_line_splice_normalizer_top.sv @@
// Source line splice normalizer: newline folding, backslash-newline removal,
// line/column tracking. Depends on slsn_pkg.
//
//  channel | valid     | stall     | word                  | per item
//  src     | src_valid | src_stall | slsn_pkg::src_word_t  | one raw byte in
//  res     | res_valid | res_stall | slsn_pkg::res_word_t  | zero to two words out
//
// One byte per cycle sustained while the queue holds at most one word: a byte is
// registered in the input register, then the decode logic pushes its zero, one or
// two words into a three-entry result queue, whose head is the result word.
// The input register advances only while the queue holds at most one word;
// a two-word run therefore stalls the source when the result side drains
// one word per cycle. Reset (arst_n low) clears all flags, sets line and
// column to 1 and empties the queue.
module source_line_splice_normalizer_top (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                src_valid,
	output logic                src_stall,
	input  slsn_pkg::src_word_t src_word,
	output logic                res_valid,
	input  logic                res_stall,
	output slsn_pkg::res_word_t res_word
);
	import slsn_pkg::*;

	function automatic logic [1:0] ptr_add(input logic [1:0] p, input logic [1:0] k);
		logic [2:0] s;
		s = {1'b0, p} + {1'b0, k};
		if (s >= 3'(RES_DEPTH)) begin
			s = s - 3'(RES_DEPTH);
		end
		return s[1:0];
	endfunction

	// input register
	logic      valid_s1;
	src_word_t word_s1;

	// stream state
	logic                   held_q;
	logic                   swallow_q;
	logic                   ended_q;
	logic [LINE_BITS-1:0]   line_q;
	logic [COLUMN_BITS-1:0] col_q;

	// result queue
	res_word_t  queue_q [RES_DEPTH];
	logic [1:0] head_q;
	logic [1:0] tail_q;
	logic [1:0] count_q;

	logic go;
	logic pop;

	assign go        = valid_s1 && (count_q <= 2'd1);
	assign src_stall = valid_s1 && !go;
	assign pop       = res_valid && !res_stall;
	assign res_valid = (count_q != 2'd0);
	assign res_word  = queue_q[head_q];

	// decode of the registered byte
	logic                   held_d;
	logic                   swallow_d;
	logic                   ended_d;
	logic [LINE_BITS-1:0]   line_d;
	logic [COLUMN_BITS-1:0] col_d;
	logic [1:0]             n_d;
	res_word_t              r0;
	res_word_t              r1;

	always_comb begin
		logic [7:0] b;
		logic       stop;
		logic       skip;
		logic       is_nl;
		b         = word_s1.in_byte;
		stop      = word_s1.end_of_input || (b == CH_NUL);
		is_nl     = (b == CH_CR) || (b == CH_LF);
		skip      = 1'b0;
		held_d    = held_q;
		swallow_d = swallow_q;
		ended_d   = ended_q;
		line_d    = line_q;
		col_d     = col_q;
		n_d       = 2'd0;
		r0        = '0;
		r1        = '0;
		if (ended_q) begin
			r0  = '{out_char: CH_NUL, is_end: 1'b1, line_number: line_q,
				column_number: col_q, last_of_run: 1'b1};
			n_d = 2'd1;
		end else if (stop) begin
			if (held_q) begin
				held_d = 1'b0;
				if (col_d != COLUMN_MAX) begin
					col_d = col_d + COLUMN_BITS'(1);
				end
				r0  = '{out_char: CH_BACKSLASH, is_end: 1'b0, line_number: line_d,
					column_number: col_d, last_of_run: 1'b0};
				r1  = '{out_char: CH_NUL, is_end: 1'b1, line_number: line_d,
					column_number: col_d, last_of_run: 1'b1};
				n_d = 2'd2;
			end else begin
				r0  = '{out_char: CH_NUL, is_end: 1'b1, line_number: line_d,
					column_number: col_d, last_of_run: 1'b1};
				n_d = 2'd1;
			end
			swallow_d = 1'b0;
			ended_d   = 1'b1;
		end else begin
			// drop an LF that completes a CRLF
			if (swallow_q) begin
				swallow_d = 1'b0;
				skip      = (b == CH_LF);
			end
			if (!skip && held_q) begin
				held_d = 1'b0;
				if (is_nl) begin
					// splice: the line end is consumed with the backslash
					if (line_d != LINE_MAX) begin
						line_d = line_d + LINE_BITS'(1);
					end
					col_d     = COLUMN_BITS'(1);
					swallow_d = (b == CH_CR);
					skip      = 1'b1;
				end else begin
					if (col_d != COLUMN_MAX) begin
						col_d = col_d + COLUMN_BITS'(1);
					end
					r0  = '{out_char: CH_BACKSLASH, is_end: 1'b0, line_number: line_d,
						column_number: col_d, last_of_run: 1'b0};
					n_d = 2'd1;
				end
			end
			if (!skip) begin
				if (b == CH_BACKSLASH) begin
					held_d = 1'b1;
				end else begin
					if (is_nl) begin
						if (line_d != LINE_MAX) begin
							line_d = line_d + LINE_BITS'(1);
						end
						col_d     = COLUMN_BITS'(1);
						swallow_d = (b == CH_CR);
					end else if (col_d != COLUMN_MAX) begin
						col_d = col_d + COLUMN_BITS'(1);
					end
					if (n_d == 2'd0) begin
						r0 = '{out_char: (is_nl ? CH_LF : b), is_end: 1'b0,
							line_number: line_d, column_number: col_d, last_of_run: 1'b0};
					end else begin
						r1 = '{out_char: (is_nl ? CH_LF : b), is_end: 1'b0,
							line_number: line_d, column_number: col_d, last_of_run: 1'b0};
					end
					n_d = n_d + 2'd1;
				end
			end
			if (n_d == 2'd1) begin
				r0.last_of_run = 1'b1;
			end else if (n_d == 2'd2) begin
				r1.last_of_run = 1'b1;
			end
		end
	end

	logic [1:0] push;
	assign push = go ? n_d : 2'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			held_q    <= 1'b0;
			swallow_q <= 1'b0;
			ended_q   <= 1'b0;
			line_q    <= LINE_BITS'(1);
			col_q     <= COLUMN_BITS'(1);
			head_q    <= '0;
			tail_q    <= '0;
			count_q   <= '0;
		end else begin
			if (!src_stall) begin
				valid_s1 <= src_valid;
			end
			if (go) begin
				held_q    <= held_d;
				swallow_q <= swallow_d;
				ended_q   <= ended_d;
				line_q    <= line_d;
				col_q     <= col_d;
			end
			tail_q  <= ptr_add(tail_q, push);
			head_q  <= ptr_add(head_q, {1'b0, pop});
			count_q <= count_q + push - {1'b0, pop};
		end
	end

	// payload registers, no reset
	always_ff @(posedge clk) begin
		if (!src_stall) begin
			word_s1 <= src_word;
		end
		if (push != 2'd0) begin
			queue_q[tail_q] <= r0;
		end
		if (push == 2'd2) begin
			queue_q[ptr_add(tail_q, 2'd1)] <= r1;
		end
	end

endmodule

@@ hdl/slsn_checker.sv @@
// Port-level checks for the source line splice normalizer, bound to the top.
// Depends on slsn_pkg and source_line_splice_normalizer_top.
module slsn_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                res_valid,
	input logic                res_stall,
	input slsn_pkg::res_word_t res_word
);
	import slsn_pkg::*;

	// a stalled result word holds
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(res_word))
		else $error("result word changed while stalled");

	// the end word always closes its run
	a_end_last: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_word.is_end |-> res_word.last_of_run)
		else $error("end word not marked last of run");

	// both words of a run are queued together, so the second follows at once
	a_run_whole: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_stall && !res_word.last_of_run |=> res_valid)
		else $error("second word of run missing");

	// a line end starts column one, and CR never leaves the block
	a_newline: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_word.is_end |->
			res_word.out_char != CH_CR &&
			(res_word.out_char != CH_LF || res_word.column_number == COLUMN_BITS'(1)))
		else $error("bad line end word");

endmodule

bind source_line_splice_normalizer_top slsn_checker u_slsn_checker (.*);

@@ tb/sv/tb.sv @@
// Testbench for source_line_splice_normalizer_top: line end folding, backslash splices,
// line/column tracking and end-of-stream handling, checked word by word against a predictor.
// Depends on slsn_pkg and the RTL of the top level.
module tb;
	import slsn_pkg::*;

	logic      clk;
	logic      arst_n;
	logic      src_valid;
	logic      src_stall;
	src_word_t src_word;
	logic      res_valid;
	logic      res_stall;
	res_word_t res_word;

	source_line_splice_normalizer_top u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.src_valid (src_valid),
		.src_stall (src_stall),
		.src_word  (src_word),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res_word  (res_word)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Predictor state
	logic                   bs_held     = 1'b0;
	logic                   drop_lf     = 1'b0;
	logic                   stream_done = 1'b0;
	logic [LINE_BITS-1:0]   line_cnt    = LINE_BITS'(1);
	logic [COLUMN_BITS-1:0] col_cnt     = COLUMN_BITS'(1);

	res_word_t expected_chars[$];
	int        mismatches = 0;
	int        words_seen = 0;

	// Sender and receiver pacing
	bit steady      = 1'b0;
	bit quiet       = 1'b0;
	int burst_left  = 0;
	int hold_request = 0;
	int hold_left   = 0;
	int stall_run   = 0;
	int free_run    = 0;

	function automatic void bump_col();
		if (col_cnt != COLUMN_MAX)
			col_cnt++;
	endfunction

	function automatic void line_end(input logic was_cr);
		if (line_cnt != LINE_MAX)
			line_cnt++;
		col_cnt = COLUMN_BITS'(1);
		drop_lf = was_cr;
	endfunction

	function automatic res_word_t char_word(input logic [7:0] ch, input logic fin);
		res_word_t r;
		r.out_char      = ch;
		r.is_end        = fin;
		r.line_number   = line_cnt;
		r.column_number = col_cnt;
		r.last_of_run   = 1'b0;
		return r;
	endfunction

	function automatic void normalize_byte(input src_word_t w);
		logic [7:0] b;
		logic       ends;
		logic       done;
		res_word_t  run[$];
		b    = w.in_byte;
		ends = w.end_of_input || (b == CH_NUL);
		done = 1'b0;
		if (stream_done) begin
			run.push_back(char_word(CH_NUL, 1'b1));
		end else if (ends) begin
			// flush a held backslash before the end word
			if (bs_held) begin
				bs_held = 1'b0;
				bump_col();
				run.push_back(char_word(CH_BACKSLASH, 1'b0));
			end
			drop_lf     = 1'b0;
			stream_done = 1'b1;
			run.push_back(char_word(CH_NUL, 1'b1));
		end else begin
			if (drop_lf) begin
				drop_lf = 1'b0;
				done    = (b == CH_LF);
			end
			if (!done && bs_held) begin
				bs_held = 1'b0;
				if (b == CH_CR || b == CH_LF) begin
					line_end(b == CH_CR);
					done = 1'b1;
				end else begin
					bump_col();
					run.push_back(char_word(CH_BACKSLASH, 1'b0));
				end
			end
			if (!done) begin
				if (b == CH_BACKSLASH) begin
					bs_held = 1'b1;
				end else if (b == CH_CR || b == CH_LF) begin
					line_end(b == CH_CR);
					run.push_back(char_word(CH_LF, 1'b0));
				end else begin
					bump_col();
					run.push_back(char_word(b, 1'b0));
				end
			end
		end
		if (run.size() > 0)
			run[run.size()-1].last_of_run = 1'b1;
		foreach (run[i])
			expected_chars.push_back(run[i]);
	endfunction

	task automatic send_byte(input logic [7:0] b, input logic eoi = 1'b0);
		src_word_t w;
		int        gap;
		w.in_byte      = b;
		w.end_of_input = eoi;
		src_valid <= 1'b1;
		src_word  <= w;
		do @(posedge clk); while (src_stall);
		normalize_byte(w);
		if (!steady) begin
			if (burst_left > 0) begin
				burst_left--;
			end else begin
				gap = $urandom_range(1, 8);
				src_valid <= 1'b0;
				repeat (gap) @(posedge clk);
				burst_left = $urandom_range(0, 30);
			end
		end
	endtask

	function automatic logic [7:0] plain_char();
		logic [7:0] b;
		do b = 8'($urandom_range(32, 126)); while (b == CH_BACKSLASH);
		return b;
	endfunction

	task automatic report_mismatch(input string what);
		mismatches++;
		$display("mismatch at word %0d: %s", words_seen, what);
	endtask

	// Receiver: own stall pattern, plus a long hold when asked
	always @(posedge clk) begin
		if (hold_request > 0) begin
			hold_left    = hold_request;
			hold_request = 0;
		end
		if (hold_left > 0) begin
			hold_left--;
			res_stall <= 1'b1;
		end else if (quiet) begin
			res_stall <= 1'b0;
		end else if (stall_run > 0) begin
			stall_run--;
			res_stall <= 1'b1;
		end else if (free_run > 0) begin
			free_run--;
			res_stall <= 1'b0;
		end else begin
			free_run  = $urandom_range(0, 20);
			stall_run = $urandom_range(1, 5);
			res_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		res_word_t want;
		if (arst_n && res_valid && !res_stall) begin
			words_seen++;
			if (expected_chars.size() == 0) begin
				report_mismatch("word with nothing expected");
			end else begin
				want = expected_chars.pop_front();
				if (res_word.out_char !== want.out_char)
					report_mismatch($sformatf("out_char %h, want %h",
						res_word.out_char, want.out_char));
				if (res_word.is_end !== want.is_end)
					report_mismatch($sformatf("is_end %b, want %b",
						res_word.is_end, want.is_end));
				if (res_word.line_number !== want.line_number)
					report_mismatch($sformatf("line_number %0d, want %0d",
						res_word.line_number, want.line_number));
				if (res_word.column_number !== want.column_number)
					report_mismatch($sformatf("column_number %0d, want %0d",
						res_word.column_number, want.column_number));
				if (res_word.last_of_run !== want.last_of_run)
					report_mismatch($sformatf("last_of_run %b, want %b",
						res_word.last_of_run, want.last_of_run));
			end
		end
	end

	task automatic test_field_extremes_and_splices();
		send_byte(8'h41);
		send_byte(8'hFF);
		send_byte(8'h01);
		send_byte(8'h80);
		send_byte(CH_LF);
		send_byte(CH_CR);
		send_byte(CH_LF);           // dropped after CR
		send_byte(CH_CR);
		send_byte(8'h62);           // CR followed by a plain byte
		send_byte(CH_BACKSLASH);
		send_byte(CH_LF);           // splice on LF
		send_byte(CH_BACKSLASH);
		send_byte(CH_CR);
		send_byte(CH_LF);           // splice on CRLF
		send_byte(CH_BACKSLASH);
		send_byte(CH_CR);
		send_byte(8'h78);
		send_byte(CH_BACKSLASH);
		send_byte(CH_BACKSLASH);
		send_byte(8'h79);           // flushed backslash plus byte
		send_byte(CH_CR);
		send_byte(CH_CR);
		send_byte(CH_LF);
		send_byte(8'h7F);
	endtask

	task automatic test_quiet_long_line();
		steady = 1'b1;
		quiet  = 1'b1;
		send_byte(CH_LF);
		repeat (40)
			send_byte(plain_char());
		send_byte(CH_BACKSLASH);
		send_byte(8'h71);
		send_byte(CH_CR);
		send_byte(CH_LF);
		steady = 1'b0;
		quiet  = 1'b0;
	endtask

	task automatic test_backpressure_fill();
		steady       = 1'b1;
		hold_request = 300;
		repeat (40) begin
			if ($urandom_range(0, 3) == 0)
				send_byte(CH_BACKSLASH);
			send_byte(plain_char());
		end
		steady = 1'b0;
	endtask

	task automatic test_random_source();
		int sent;
		int pick;
		sent = 0;
		while (sent < 1200) begin
			pick = $urandom_range(0, 99);
			if (pick < 45) begin
				send_byte(plain_char());
				sent += 1;
			end else if (pick < 55) begin
				send_byte(8'($urandom_range(1, 255)));
				sent += 1;
			end else if (pick < 63) begin
				send_byte(CH_LF);
				sent += 1;
			end else if (pick < 69) begin
				send_byte(CH_CR);
				sent += 1;
			end else if (pick < 75) begin
				send_byte(CH_CR);
				send_byte(CH_LF);
				sent += 2;
			end else if (pick < 83) begin
				send_byte(CH_BACKSLASH);
				if ($urandom_range(0, 1)) begin
					send_byte(CH_LF);
					sent += 2;
				end else begin
					send_byte(CH_CR);
					send_byte($urandom_range(0, 1) ? CH_LF : plain_char());
					sent += 3;
				end
			end else if (pick < 90) begin
				send_byte(CH_BACKSLASH);
				send_byte(plain_char());
				sent += 2;
			end else if (pick < 95) begin
				send_byte(CH_BACKSLASH);
				send_byte(CH_BACKSLASH);
				sent += 2;
			end else begin
				send_byte(CH_BACKSLASH);
				send_byte(CH_CR);
				send_byte(CH_CR);
				sent += 3;
			end
		end
	endtask

	task automatic test_stream_end();
		logic [7:0] b;
		if ($urandom_range(0, 1))
			send_byte(CH_CR);
		if ($urandom_range(0, 3) != 0)
			send_byte(CH_BACKSLASH);
		// terminate on NUL or on the end flag with any byte
		if ($urandom_range(0, 1))
			send_byte(CH_NUL);
		else
			send_byte(8'($urandom_range(0, 255)), 1'b1);
		send_byte(8'hFF, 1'b1);
		send_byte(CH_NUL);
		send_byte(CH_BACKSLASH);
		send_byte(CH_CR);
		send_byte(8'h41);
		repeat (40) begin
			b = 8'($urandom_range(0, 255));
			send_byte(b, 1'($urandom_range(0, 1)));
		end
	endtask

	initial begin
		arst_n    = 1'b0;
		src_valid = 1'b0;
		src_word  = '0;
		res_stall = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_field_extremes_and_splices();
		test_backpressure_fill();
		test_quiet_long_line();
		test_random_source();
		test_stream_end();

		src_valid <= 1'b0;
		while (expected_chars.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);

		if (mismatches == 0 && expected_chars.size() == 0)
			$display("source_line_splice_normalizer_top regression: pass");
		else
			$display("source_line_splice_normalizer_top regression: fail");
		$finish;
	end

	initial begin
		#20000000;
		$display("source_line_splice_normalizer_top regression: fail");
		$finish;
	end

endmodule
